// ----- hdl/bba_pkg.sv -----
// Shared types and codes for the buddy block allocator.
package bba_pkg;

	// result status codes
	localparam logic [1:0] ALLOC_GRANTED = 2'd0;
	localparam logic [1:0] ALLOC_INVALID = 2'd1;
	localparam logic [1:0] ALLOC_NOSPACE = 2'd2;

	// tree node states
	localparam logic [1:0] NODE_FREE    = 2'd0;
	localparam logic [1:0] NODE_PARTIAL = 2'd1;
	localparam logic [1:0] NODE_FULL    = 2'd2;

	// configuration register indexes
	localparam logic CFG_HEAP_BASE    = 1'b0;
	localparam logic CFG_REGION_COUNT = 1'b1;

	// block sizes (log2) and tree depths fit in five bits
	localparam int LOG_W = 5;

	typedef struct packed {
		logic       clear;
		logic       load;
		logic       want_inc;
		logic       root;
		logic       descend;
		logic       up;
		logic       sibling;
		logic       next_region;
		logic       mark;
		logic       sib;
		logic       parent;
		logic       finish;
		logic [1:0] code;
	} bba_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic size_big;
		logic want_more;
		logic reg_end;
		logic node_root;
		logic node_odd;
		logic is_full;
		logic is_free;
		logic at_target;
	} bba_stat_t;

endpackage

// ----- hdl/buddy_block_allocator_top.sv -----
// Top level of the buddy block allocator.
//
// A request beat is taken when start is high and busy is low; busy stays high
// until the result beat has been issued. Each result is shown for one cycle,
// marked by done, and the receiver cannot stall it. After reset the block
// sweeps its node-state memory to free, one entry per cycle, over all
// REGIONS * 2^(MAX_BLOCK_LOG2 - MIN_BLOCK_LOG2 + 1) entries (32768 with the
// defaults); busy is high meanwhile, config writes are taken as usual.
// Per request, once the accepting edge has loaded the size, the block first
// rounds it up by doubling the block size step by step from the minimum block
// (a too-large size goes straight to the finish step), then per region searched
// does one setup step, visits tree nodes with one read of the tree memory
// plus a decision each, and backtracks (climbing one level out of a failed
// subtree, moving to the right sibling, or leaving the region); one more
// setup step ends the search when no region fits. A grant then fixes the
// ancestor states level by level up to the root. The finish step registers
// the result and done is shown in the cycle after it.
// The cost grows with fragmentation and region count.
//
// Config: cfg_index 0 = heap_base, 1 = region_count (low three bits kept;
// values above REGIONS saturate, zero gives no-space). Write only while idle.
// Status: 0 granted, 1 too large (>= 2^MAX_BLOCK_LOG2), 2 no free block.
module buddy_block_allocator_top import bba_pkg::*; #(
	parameter int REGIONS        = 4,
	parameter int MAX_BLOCK_LOG2 = 24,
	parameter int MIN_BLOCK_LOG2 = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] request_size,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	output logic        done,
	output logic [1:0]  alloc_status,
	output logic [31:0] block_address
);

	bba_cmd_t  cmd;
	bba_stat_t stat;

	// controller: walk sequencing
	bba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// datapath: tree memory, counters, result beat
	bba_datapath #(
		.REGIONS        (REGIONS),
		.MAX_BLOCK_LOG2 (MAX_BLOCK_LOG2),
		.MIN_BLOCK_LOG2 (MIN_BLOCK_LOG2)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.request_size  (request_size),
		.cmd           (cmd),
		.stat          (stat),
		.done          (done),
		.alloc_status  (alloc_status),
		.block_address (block_address)
	);

endmodule

// ----- hdl/bba_datapath.sv -----
// Datapath: config registers, tree memory, walk counters and result registers.
module bba_datapath import bba_pkg::*; #(
	parameter int REGIONS        = 4,
	parameter int MAX_BLOCK_LOG2 = 24,
	parameter int MIN_BLOCK_LOG2 = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic [31:0] request_size,
	input  bba_cmd_t    cmd,
	output bba_stat_t   stat,
	output logic        done,
	output logic [1:0]  alloc_status,
	output logic [31:0] block_address
);

	localparam int TREE_LEVELS = MAX_BLOCK_LOG2 - MIN_BLOCK_LOG2;
	localparam int NODE_W      = TREE_LEVELS + 1;
	localparam int REG_W       = $clog2(REGIONS + 1);
	localparam int RIDX_W      = (REGIONS > 1) ? $clog2(REGIONS) : 1;
	localparam int ADDR_W      = RIDX_W + NODE_W;
	localparam int DEPTH       = REGIONS << NODE_W;
	localparam logic [31:0] OFF_MASK = 32'((64'd1 << MAX_BLOCK_LOG2) - 64'd1);

	logic [31:0]       heap_base_q;
	logic [2:0]        region_count_q;
	logic [31:0]       size_q;
	logic [LOG_W-1:0]  want_q;
	logic [LOG_W-1:0]  dep_q;
	logic [REG_W-1:0]  reg_q;
	logic [NODE_W-1:0] node_q;
	logic [NODE_W-1:0] hit_q;
	logic              cur_full_q;
	logic [ADDR_W:0]   clr_q;
	logic              done_q;

	logic [1:0]        mem [0:DEPTH-1];
	logic [1:0]        rdata_q;

	logic [RIDX_W-1:0] ridx;
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	logic [1:0]        wr_data, par_val;
	logic              wr_en;
	logic [7:0]        used;
	logic [LOG_W-1:0]  target;
	logic [31:0]       addr_sum;

	assign ridx    = RIDX_W'(reg_q);
	assign rd_addr = {ridx, node_q ^ NODE_W'(cmd.sib)};
	assign par_val = (cur_full_q && rdata_q == NODE_FULL) ? NODE_FULL : NODE_PARTIAL;
	assign used    = (8'(region_count_q) > 8'(REGIONS)) ? 8'(REGIONS) : 8'(region_count_q);
	assign target  = LOG_W'(MAX_BLOCK_LOG2) - want_q;

	always_comb begin
		wr_en   = cmd.clear | cmd.mark | cmd.parent;
		wr_addr = {ridx, node_q};
		wr_data = NODE_FULL;
		if (cmd.clear) begin
			wr_addr = clr_q[ADDR_W-1:0];
			wr_data = NODE_FREE;
		end else if (cmd.parent) begin
			wr_addr = {ridx, node_q >> 1};
			wr_data = par_val;
		end
	end

	assign stat.clr_done  = (clr_q == (ADDR_W+1)'(DEPTH));
	assign stat.size_big  = (size_q >> MAX_BLOCK_LOG2) != 32'd0;
	assign stat.want_more = (want_q < LOG_W'(MAX_BLOCK_LOG2)) &&
		((32'd1 << want_q) < size_q);
	assign stat.reg_end   = 8'(reg_q) >= used;
	assign stat.node_root = (node_q == NODE_W'(1));
	assign stat.node_odd  = node_q[0];
	assign stat.is_full   = (rdata_q == NODE_FULL);
	assign stat.is_free   = (rdata_q == NODE_FREE);
	assign stat.at_target = (dep_q == target);

	assign addr_sum = heap_base_q + (32'(reg_q) << MAX_BLOCK_LOG2) +
		((32'(hit_q) << want_q) & OFF_MASK);

	// tree memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q    <= 32'd0;
			region_count_q <= 3'd4;
			clr_q          <= '0;
			done_q         <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_HEAP_BASE:    heap_base_q    <= cfg_data;
					CFG_REGION_COUNT: region_count_q <= cfg_data[2:0];
					default: ;
				endcase
			end
			if (cmd.clear) begin
				clr_q <= clr_q + 1'b1;
			end
			done_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			size_q <= request_size;
			want_q <= LOG_W'(MIN_BLOCK_LOG2);
			reg_q  <= '0;
		end
		if (cmd.want_inc) begin
			want_q <= want_q + 1'b1;
		end
		if (cmd.next_region) begin
			reg_q <= reg_q + 1'b1;
		end
		if (cmd.root) begin
			node_q <= NODE_W'(1);
			dep_q  <= '0;
		end else if (cmd.descend) begin
			node_q <= node_q << 1;
			dep_q  <= dep_q + 1'b1;
		end else if (cmd.up) begin
			node_q <= node_q >> 1;
			dep_q  <= dep_q - 1'b1;
		end else if (cmd.sibling) begin
			node_q <= node_q + 1'b1;
		end else if (cmd.parent) begin
			node_q <= node_q >> 1;
		end
		if (cmd.mark) begin
			hit_q      <= node_q;
			cur_full_q <= 1'b1;
		end else if (cmd.parent) begin
			cur_full_q <= (par_val == NODE_FULL);
		end
		if (cmd.finish) begin
			alloc_status  <= cmd.code;
			block_address <= (cmd.code == ALLOC_GRANTED) ? addr_sum : 32'd0;
		end
	end

	assign done = done_q;

	a_done_follows_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(cmd.finish))
		else $error("result strobe without finish");

	a_reject_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && alloc_status != ALLOC_GRANTED) |-> block_address == 32'd0)
		else $error("address not zero on a refused request");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (alloc_status == ALLOC_GRANTED || alloc_status == ALLOC_INVALID ||
			alloc_status == ALLOC_NOSPACE))
		else $error("unknown status code on result beat");

endmodule

// ----- hdl/bba_ctrl.sv -----
// Controller: sequences clearing, size rounding, tree walk and ancestor update.
module bba_ctrl import bba_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  bba_stat_t stat,
	output bba_cmd_t  cmd,
	output logic      busy
);

	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_SIZE   = 4'd2;
	localparam logic [3:0] S_REGION = 4'd3;
	localparam logic [3:0] S_RD     = 4'd4;
	localparam logic [3:0] S_EV     = 4'd5;
	localparam logic [3:0] S_BACK   = 4'd6;
	localparam logic [3:0] S_UP     = 4'd7;
	localparam logic [3:0] S_UPE    = 4'd8;
	localparam logic [3:0] S_FIN    = 4'd9;

	logic [3:0] state_q, state_d;
	logic [1:0] code_q, code_d;

	always_comb begin
		state_d = state_q;
		code_d  = code_q;
		cmd     = '0;
		cmd.code = code_q;
		case (state_q)
			S_CLEAR: begin
				if (stat.clr_done) begin
					state_d = S_IDLE;
				end else begin
					cmd.clear = 1'b1;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_SIZE;
				end
			end
			S_SIZE: begin
				if (stat.size_big) begin
					code_d  = ALLOC_INVALID;
					state_d = S_FIN;
				end else if (stat.want_more) begin
					cmd.want_inc = 1'b1;
				end else begin
					state_d = S_REGION;
				end
			end
			S_REGION: begin
				if (stat.reg_end) begin
					code_d  = ALLOC_NOSPACE;
					state_d = S_FIN;
				end else begin
					cmd.root = 1'b1;
					state_d  = S_RD;
				end
			end
			S_RD: state_d = S_EV;
			S_EV: begin
				if (stat.at_target && stat.is_free) begin
					cmd.mark = 1'b1;
					state_d  = S_UP;
				end else if (stat.is_full || stat.at_target) begin
					state_d = S_BACK;
				end else begin
					cmd.descend = 1'b1;
					state_d     = S_RD;
				end
			end
			S_BACK: begin
				if (stat.node_root) begin
					cmd.next_region = 1'b1;
					state_d         = S_REGION;
				end else if (stat.node_odd) begin
					cmd.up = 1'b1;
				end else begin
					cmd.sibling = 1'b1;
					state_d     = S_RD;
				end
			end
			S_UP: begin
				if (stat.node_root) begin
					code_d  = ALLOC_GRANTED;
					state_d = S_FIN;
				end else begin
					cmd.sib = 1'b1;
					state_d = S_UPE;
				end
			end
			S_UPE: begin
				cmd.parent = 1'b1;
				state_d    = S_UP;
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			code_q  <= ALLOC_GRANTED;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	a_full_backtracks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EV && stat.is_full) |=> state_q == S_BACK)
		else $error("full node not skipped");

	a_mark_free_target: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mark |-> (stat.at_target && stat.is_free))
		else $error("marked a node that is not a free target");

	a_fin_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN |=> state_q == S_IDLE)
		else $error("finish did not return to idle");

endmodule

// ----- tb/tb_buddy_block_allocator_top.sv -----
// Testbench for the buddy block allocator: directed and random requests checked against a tree model.
`timescale 1ns / 1ps

module tb_buddy_block_allocator_top;
	import bba_pkg::*;

	localparam int REGIONS   = 4;
	localparam int MAX_LOG2  = 24;
	localparam int MIN_LOG2  = 12;
	localparam int SLOTS     = 1 << (MAX_LOG2 - MIN_LOG2 + 1);

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] address;
	} grant_t;

	// Tree model of the heap plus the queue of grants still to come out of the block.
	class alloc_scoreboard;
		logic [1:0]  tree [REGIONS][SLOTS];
		logic [31:0] heap_base;
		logic [2:0]  region_count;
		grant_t      grants_due [$];
		int          errors, n_granted, n_invalid, n_nospace;

		function new();
			heap_base    = '0;
			region_count = 3'd4;
			errors = 0; n_granted = 0; n_invalid = 0; n_nospace = 0;
			foreach (tree[r, n]) tree[r][n] = NODE_FREE;
		endfunction

		function void set_reg(logic idx, logic [31:0] value);
			if (idx == CFG_HEAP_BASE) heap_base = value;
			else region_count = value[2:0];
		endfunction

		function int pending();
			return grants_due.size();
		endfunction

		// depth first, left before right; ancestors refreshed on the way back out
		function bit claim(int rg, int node, int cur, int want, output int hit);
			int l, r;
			hit = 0;
			if (node >= SLOTS || cur < want) return 0;
			if (tree[rg][node] == NODE_FULL) return 0;
			if (cur == want) begin
				if (tree[rg][node] != NODE_FREE) return 0;
				tree[rg][node] = NODE_FULL;
				hit = node;
				return 1;
			end
			l = node * 2;
			r = l + 1;
			if (r >= SLOTS) return 0;
			if (claim(rg, l, cur - 1, want, hit) || claim(rg, r, cur - 1, want, hit)) begin
				tree[rg][node] = (tree[rg][l] == NODE_FULL && tree[rg][r] == NODE_FULL) ?
					NODE_FULL : NODE_PARTIAL;
				return 1;
			end
			return 0;
		endfunction

		function void note_request(logic [31:0] size);
			grant_t g;
			int want, used, hit;
			logic [31:0] offset;
			g = '{status: ALLOC_NOSPACE, address: '0};
			if (size >= (32'd1 << MAX_LOG2)) begin
				g.status = ALLOC_INVALID;
			end else begin
				want = MIN_LOG2;
				while (want < MAX_LOG2 && (32'd1 << want) < size) want++;
				used = (region_count > REGIONS) ? REGIONS : region_count;
				for (int rg = 0; rg < used; rg++) begin
					if (claim(rg, 1, MAX_LOG2, want, hit)) begin
						offset = (hit - (1 << (MAX_LOG2 - want))) << want;
						g.status  = ALLOC_GRANTED;
						g.address = heap_base + (rg << MAX_LOG2) + offset;
						break;
					end
				end
			end
			case (g.status)
				ALLOC_GRANTED: n_granted++;
				ALLOC_INVALID: n_invalid++;
				default:       n_nospace++;
			endcase
			grants_due.push_back(g);
		endfunction

		function void check_result(logic [1:0] status, logic [31:0] address);
			grant_t g;
			if (grants_due.size() == 0) begin
				$error("unexpected result beat: status %0d address %h", status, address);
				errors++;
				return;
			end
			g = grants_due.pop_front();
			if (status !== g.status) begin
				$error("alloc_status: expected %0d actual %0d", g.status, status);
				errors++;
			end
			if (address !== g.address) begin
				$error("block_address: expected %h actual %h", g.address, address);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic        busy;
	logic [31:0] request_size = '0;
	logic        cfg_we = 0;
	logic        cfg_index = 0;
	logic [31:0] cfg_data = '0;
	logic        done;
	logic [1:0]  alloc_status;
	logic [31:0] block_address;

	alloc_scoreboard sb = new();

	buddy_block_allocator_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.request_size(request_size), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .alloc_status(alloc_status),
		.block_address(block_address)
	);

	always #2 clk = ~clk;

	// result beat lasts one cycle; sample pre-edge values at the edge closing it
	always @(posedge clk)
		if (arst_n && done) sb.check_result(alloc_status, block_address);

	// One register write; the task waits with cfg_we low before returning, so cfg_we never drops and rises in one step.
	task automatic write_reg(logic idx, logic [31:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
		sb.set_reg(idx, value);
	endtask

	// Random gap, then hold start until busy is seen low at a clock edge.
	// With no gap, start simply stays high into the next request.
	task automatic send_request(logic [31:0] size);
		int gap;
		gap = $urandom_range(0, 8);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start        <= 1'b1;
		request_size <= size;
		do @(posedge clk); while (busy);
		sb.note_request(size);
	endtask

	// Drain all results and let the block settle before touching config.
	task automatic drain();
		start <= 1'b0;
		while (sb.pending() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Mostly small sizes so the heap fragments slowly; some huge ones fill
	// regions quickly, and raw 32-bit values mostly land in the too-large case.
	function automatic logic [31:0] pick_size();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 8)       return $urandom_range(0, 4096);
		else if (sel < 55) return $urandom_range(1, 65536);
		else if (sel < 75) return $urandom_range(1, 1 << 20);
		else if (sel < 84) return $urandom_range(1, (1 << 24) - 1);
		else if (sel < 92) return $urandom;
		else               return 32'd1 << $urandom_range(MIN_LOG2, MAX_LOG2 - 1);
	endfunction

	logic [31:0] phase_base [6];
	logic [2:0]  phase_regions [6];
	logic [31:0] directed [20];

	initial begin
		// edge sizes first: zero, minimum and its neighbors, powers of two and
		// one past, largest legal size, first too-large size, all ones
		directed = '{32'd0, 32'd1, 32'd4095, 32'd4096, 32'd4097, 32'd8192,
			32'd8193, 32'd65536, 32'd1 << 20, (32'd1 << 22) + 1, 32'd1 << 23,
			(32'd1 << 24) - 1, 32'd1 << 24, 32'hFFFF_FFFF, 32'h8000_0000,
			32'd12288, 32'd0, 32'h0055_5555, 32'h00AA_AAAA, 32'd2};
		// base extremes including wrap past 2^32; region counts zero,
		// saturating seven and each legal count
		phase_base    = '{32'h8000_0000, 32'hFFFF_FFFF, $urandom, 32'hFFF0_0000,
			$urandom, 32'h0000_0000};
		phase_regions = '{3'd1, 3'd2, 3'd0, 3'd7, 3'd3, 3'd4};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset config: base 0, all regions
		foreach (directed[i]) send_request(directed[i]);
		drain();

		for (int p = 0; p < 6; p++) begin
			write_reg(CFG_HEAP_BASE, phase_base[p]);
			write_reg(CFG_REGION_COUNT, {29'd0, phase_regions[p]});
			for (int i = 0; i < 88; i++) send_request(pick_size());
			drain();
		end

		repeat (50) @(posedge clk);
		$display("Covered %0d grants, %0d too-large rejects, %0d no-space results",
			sb.n_granted, sb.n_invalid, sb.n_nospace);
		$display("across seven base/region-count settings from one cleared heap.");
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// watchdog: covers the post-reset sweep and heavily fragmented searches
	initial begin
		#100_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
